### rtl/sdtp_pkg.sv
// ----------------------------------------------------------------------------
// sdtp_pkg
// Shared types, keyword table and sizes for the sandbox directive parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sdtp_pkg;

  localparam int KwCount  = 13;
  localparam int PosW     = 6;
  localparam int UnitW    = 16;
  localparam int FlagW    = 16;
  localparam int KwMaxLen = 40;
  localparam int KwTextW  = KwMaxLen * 8;

  localparam logic [PosW-1:0] PosMax = 6'd63;

  typedef logic [KwCount-1:0] kw_mask_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [UnitW-1:0]   unit_t;

  typedef struct packed {
    logic  advance;
    logic  last;
    logic  unit_valid;
    unit_t text_unit;
  } item_step_t;

  localparam pos_t KwLen [KwCount] = '{
    6'd12, 6'd20, 6'd39, 6'd17, 6'd11, 6'd18, 6'd13,
    6'd30, 6'd12, 6'd22, 6'd18, 6'd15, 6'd40
  };

  // Keyword text, last character in the lowest byte.
  function automatic logic [KwTextW-1:0] kw_text(input int k);
    logic [KwTextW-1:0] t;
    begin
      case (k)
        0:  t = KwTextW'("allow-popups");
        1:  t = KwTextW'("allow-top-navigation");
        2:  t = KwTextW'("allow-top-navigation-by-user-activation");
        3:  t = KwTextW'("allow-same-origin");
        4:  t = KwTextW'("allow-forms");
        5:  t = KwTextW'("allow-pointer-lock");
        6:  t = KwTextW'("allow-scripts");
        7:  t = KwTextW'("allow-popups-to-escape-sandbox");
        8:  t = KwTextW'("allow-modals");
        9:  t = KwTextW'("allow-orientation-lock");
        10: t = KwTextW'("allow-presentation");
        11: t = KwTextW'("allow-downloads");
        12: t = KwTextW'("allow-top-navigation-to-custom-protocols");
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/sdtp_token_match.sv
// ----------------------------------------------------------------------------
// sdtp_token_match
// Keyword match state: alive mask, token position and seen mask, updated
// once per code unit; yields the final seen mask on a last item.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtp_token_match (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sdtp_pkg::item_step_t step,
  output sdtp_pkg::kw_mask_t       seen_final
);

  sdtp_pkg::kw_mask_t alive, alive_next;
  sdtp_pkg::pos_t     position, position_next;
  sdtp_pkg::kw_mask_t seen, seen_next;

  sdtp_pkg::kw_mask_t alive_u, seen_u, char_ok, close_hit_u, close_hit_e;
  sdtp_pkg::pos_t     pos_u;
  logic               is_space;
  logic               non_ascii;
  logic [7:0]         lc;
  logic [5:0]         byte_idx [sdtp_pkg::KwCount];
  logic [7:0]         kw_ch    [sdtp_pkg::KwCount];
  logic [sdtp_pkg::KwTextW-1:0] txt [sdtp_pkg::KwCount];

  always_comb begin
    is_space  = (step.text_unit == 16'h0009) || (step.text_unit == 16'h000A) ||
                (step.text_unit == 16'h000C) || (step.text_unit == 16'h000D) ||
                (step.text_unit == 16'h0020);
    non_ascii = step.text_unit[15:7] != '0;
    lc        = step.text_unit[7:0];
    if (step.text_unit[7:0] >= 8'h41 && step.text_unit[7:0] <= 8'h5A) begin
      lc = step.text_unit[7:0] + 8'h20;
    end

    for (int k = 0; k < sdtp_pkg::KwCount; k++) begin
      txt[k]         = sdtp_pkg::kw_text(k);
      byte_idx[k]    = sdtp_pkg::KwLen[k] - 6'd1 - position;
      kw_ch[k]       = txt[k][{byte_idx[k], 3'b000} +: 8];
      char_ok[k]     = (position < sdtp_pkg::KwLen[k]) && (kw_ch[k] == lc);
      close_hit_u[k] = alive[k] && (position == sdtp_pkg::KwLen[k]);
    end

    alive_u = alive;
    pos_u   = position;
    seen_u  = seen;
    if (step.unit_valid) begin
      if (is_space) begin
        seen_u  = seen | close_hit_u;
        alive_u = '1;
        pos_u   = '0;
      end else begin
        alive_u = non_ascii ? '0 : (alive & char_ok);
        pos_u   = (position < sdtp_pkg::PosMax) ? position + 6'd1 : position;
      end
    end

    for (int k = 0; k < sdtp_pkg::KwCount; k++) begin
      close_hit_e[k] = alive_u[k] && (pos_u == sdtp_pkg::KwLen[k]);
    end
    seen_final = seen_u | close_hit_e;

    if (step.last) begin
      alive_next    = '1;
      position_next = '0;
      seen_next     = '0;
    end else begin
      alive_next    = alive_u;
      position_next = pos_u;
      seen_next     = seen_u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive    <= '1;
      position <= '0;
      seen     <= '0;
    end else if (step.advance) begin
      alive    <= alive_next;
      position <= position_next;
      seen     <= seen_next;
    end
  end

endmodule

`default_nettype wire

### rtl/sdtp_out_reg.sv
// ----------------------------------------------------------------------------
// sdtp_out_reg
// Result register: maps the seen keyword set to sandboxing flags and holds
// the result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtp_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire sdtp_pkg::kw_mask_t seen,
  output logic                    load_ok,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [31:0]             m_axis_tdata   // [15:0] flags, [28:16] keywords_found
);

  logic [sdtp_pkg::FlagW-1:0] flags_c;
  logic [31:0]                data;

  always_comb begin
    flags_c     = '0;
    flags_c[0]  = 1'b1;
    flags_c[1]  = !seen[0];
    flags_c[2]  = !seen[1];
    flags_c[3]  = !seen[1] && !seen[2];
    flags_c[4]  = !seen[3];
    flags_c[5]  = !seen[4];
    flags_c[6]  = !seen[5];
    flags_c[7]  = !seen[6];
    flags_c[8]  = !seen[6];
    flags_c[9]  = 1'b1;
    flags_c[10] = !seen[7];
    flags_c[11] = !seen[8];
    flags_c[12] = !seen[9];
    flags_c[13] = !seen[10];
    flags_c[14] = !seen[11];
    flags_c[15] = !seen[12] && !seen[0] && !seen[1];
  end

  assign load_ok       = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_ok) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      data <= {3'b000, seen, flags_c};
    end
  end

endmodule

`default_nettype wire

### rtl/sandbox_directive_token_parser.sv
// ----------------------------------------------------------------------------
// sandbox_directive_token_parser
// Parses a sandboxing directive, one UTF-16 code unit per word, into the
// set of allow-keywords seen and the resulting sandboxing flags.
// ----------------------------------------------------------------------------
// Input stream: tdata carries one code unit, tuser says whether the unit is
// present (0 for an end-only word), tlast closes the directive.
// Output stream: one word per directive, given for each input word with
// tlast set: the 16 flags in the low half, the 13 keyword bits above.
// Path: an input word is held in the input register; a tlast word's result
// is then registered in the result register that drives m_axis.
// Throughput: one code unit per cycle while no tlast word waits on the result
// register; the per-keyword alive mask and token position update per unit.
// Stall: while a result waits on m_axis_tready, further code units are still
// taken; only a second tlast word waits until the result register frees.
// Reset: rst clears the token state, the seen set and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sandbox_directive_token_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] text_unit
  input  wire logic        s_axis_tuser,   // [0] unit_valid
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [15:0] flags, [28:16] keywords_found
);

  logic                 in_valid;
  sdtp_pkg::unit_t      in_unit;
  logic                 in_unit_valid;
  logic                 in_last;
  logic                 advance;
  logic                 load_ok;
  sdtp_pkg::item_step_t step;
  sdtp_pkg::kw_mask_t   seen_final;

  assign advance       = in_valid && (!in_last || load_ok);
  assign s_axis_tready = !in_valid || advance;

  assign step.advance    = advance;
  assign step.last       = in_last;
  assign step.unit_valid = in_unit_valid;
  assign step.text_unit  = in_unit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_unit       <= s_axis_tdata;
      in_unit_valid <= s_axis_tuser;
      in_last       <= s_axis_tlast;
    end
  end

  sdtp_token_match u_match (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .seen_final (seen_final)
  );

  sdtp_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && in_last),
    .seen          (seen_final),
    .load_ok       (load_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### dv/tb_sandbox_directive_token_parser.sv
// ----------------------------------------------------------------------------
// tb_sandbox_directive_token_parser
// Streams sandboxing directive strings into the parser, one code unit per
// word, with random bursts, gaps and output stalls. An in-bench copy of the
// keyword matcher predicts flags and keyword set per directive; every result
// word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sandbox_directive_token_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KwPopups    = 0;
  localparam int KwTopNav    = 1;
  localparam int KwTopNavUa  = 2;
  localparam int KwSameOrig  = 3;
  localparam int KwForms     = 4;
  localparam int KwPointer   = 5;
  localparam int KwScripts   = 6;
  localparam int KwEscape    = 7;
  localparam int KwModals    = 8;
  localparam int KwOrient    = 9;
  localparam int KwPresent   = 10;
  localparam int KwDownloads = 11;
  localparam int KwCustom    = 12;

  localparam int   CycleLimit = 300000;
  localparam int   HoldCycles = 400;
  localparam int   SettleWait = 8;
  localparam sdtp_pkg::unit_t NonAscii = 16'h0080;

  typedef struct packed {
    logic            drain;
    logic            last;
    logic            unit_valid;
    sdtp_pkg::unit_t text_unit;
  } dir_word_t;

  typedef struct packed {
    logic [15:0]        flags;
    sdtp_pkg::kw_mask_t found;
  } sandbox_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] text_unit
  logic        s_axis_tuser = 1'b0; // [0] unit_valid
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [15:0] flags, [28:16] keywords_found

  sandbox_directive_token_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dir_word_t        word_q[$];
  sandbox_verdict_t verdict_q[$];
  logic             drain_next = 1'b0;
  int               words_made = 0;
  int               err_count = 0;
  int               results_taken = 0;
  int               cycle_count = 0;
  logic             in_took = 1'b0;

  sdtp_pkg::kw_mask_t tok_alive = '1;
  sdtp_pkg::pos_t     tok_pos = '0;
  sdtp_pkg::kw_mask_t seen_kw = '0;

  function automatic string allow_keyword(int k);
    case (k)
      KwPopups:    return "allow-popups";
      KwTopNav:    return "allow-top-navigation";
      KwTopNavUa:  return "allow-top-navigation-by-user-activation";
      KwSameOrig:  return "allow-same-origin";
      KwForms:     return "allow-forms";
      KwPointer:   return "allow-pointer-lock";
      KwScripts:   return "allow-scripts";
      KwEscape:    return "allow-popups-to-escape-sandbox";
      KwModals:    return "allow-modals";
      KwOrient:    return "allow-orientation-lock";
      KwPresent:   return "allow-presentation";
      KwDownloads: return "allow-downloads";
      KwCustom:    return "allow-top-navigation-to-custom-protocols";
      default:     return "";
    endcase
  endfunction

  function automatic logic is_blank(sdtp_pkg::unit_t u);
    return u == 16'h0009 || u == 16'h000A || u == 16'h000C || u == 16'h000D ||
           u == 16'h0020;
  endfunction

  function automatic sdtp_pkg::unit_t blank_unit();
    case ($urandom_range(0, 4))
      0:       return 16'h0009;
      1:       return 16'h000A;
      2:       return 16'h000C;
      3:       return 16'h000D;
      default: return 16'h0020;
    endcase
  endfunction

  function automatic void close_token();
    for (int k = 0; k < sdtp_pkg::KwCount; k++)
      if (tok_alive[k] && int'(tok_pos) == allow_keyword(k).len()) seen_kw[k] = 1'b1;
    tok_alive = '1;
    tok_pos = '0;
  endfunction

  function automatic void take_unit(sdtp_pkg::unit_t u);
    logic [7:0] c;
    string      kw;
    if (is_blank(u)) begin
      close_token();
      return;
    end
    if (u >= NonAscii) begin
      tok_alive = '0;
    end else begin
      c = u[7:0];
      if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
      for (int k = 0; k < sdtp_pkg::KwCount; k++) begin
        kw = allow_keyword(k);
        if (tok_alive[k] && (int'(tok_pos) >= kw.len() || kw[tok_pos] != c))
          tok_alive[k] = 1'b0;
      end
    end
    if (tok_pos != sdtp_pkg::PosMax) tok_pos = tok_pos + 1'b1;
  endfunction

  function automatic logic [15:0] sandbox_flags(sdtp_pkg::kw_mask_t s);
    logic [15:0] f;
    f = '0;
    f[0]  = 1'b1;
    f[1]  = !s[KwPopups];
    f[2]  = !s[KwTopNav];
    f[3]  = !s[KwTopNav] && !s[KwTopNavUa];
    f[4]  = !s[KwSameOrig];
    f[5]  = !s[KwForms];
    f[6]  = !s[KwPointer];
    f[7]  = !s[KwScripts];
    f[8]  = !s[KwScripts];
    f[9]  = 1'b1;
    f[10] = !s[KwEscape];
    f[11] = !s[KwModals];
    f[12] = !s[KwOrient];
    f[13] = !s[KwPresent];
    f[14] = !s[KwDownloads];
    f[15] = !s[KwCustom] && !s[KwPopups] && !s[KwTopNav];
    return f;
  endfunction

  task automatic push_word(sdtp_pkg::unit_t u, logic valid, logic last);
    word_q.push_back('{drain_next, last, valid, u});
    drain_next = 1'b0;
    words_made++;
  endtask

  task automatic push_text(string t, logic last_on_end);
    for (int i = 0; i < t.len(); i++)
      push_word(sdtp_pkg::unit_t'(t[i]), 1'b1, last_on_end && i == t.len() - 1);
  endtask

  task automatic add_token(ref sdtp_pkg::unit_t units[$]);
    string           kw;
    sdtp_pkg::unit_t tk[$];
    int              pick, n;
    logic [7:0]      c;
    kw = allow_keyword($urandom_range(0, sdtp_pkg::KwCount - 1));
    pick = $urandom_range(0, 99);
    for (int i = 0; i < kw.len(); i++) begin
      c = kw[i];
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) c = c - 8'h20;
      tk.push_back(sdtp_pkg::unit_t'(c));
    end
    if (pick < 58) begin
    end else if (pick < 68) begin
      tk[$urandom_range(0, tk.size() - 1)] =
        sdtp_pkg::unit_t'($urandom_range(16'h21, 16'h7E));
    end else if (pick < 76) begin
      n = $urandom_range(1, tk.size() - 1);
      while (tk.size() > n) void'(tk.pop_back());
    end else if (pick < 83) begin
      repeat ($urandom_range(1, 3))
        tk.push_back(sdtp_pkg::unit_t'($urandom_range(16'h61, 16'h7A)));
    end else if (pick < 89) begin
      tk[$urandom_range(0, tk.size() - 1)] =
        sdtp_pkg::unit_t'($urandom_range(16'h0080, 16'hFFFF));
    end else if (pick < 95) begin
      tk.delete();
      repeat ($urandom_range(1, 8))
        tk.push_back(sdtp_pkg::unit_t'($urandom_range(0, 16'hFFFF)));
    end else begin
      tk.delete();
      repeat ($urandom_range(55, 72))
        tk.push_back(sdtp_pkg::unit_t'($urandom_range(16'h61, 16'h7A)));
    end
    foreach (tk[i]) units.push_back(tk[i]);
  endtask

  task automatic add_directive();
    sdtp_pkg::unit_t units[$];
    int              ntok, end_kind;
    ntok = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) units.push_back(blank_unit());
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 2)) units.push_back(blank_unit());
      add_token(units);
    end
    end_kind = $urandom_range(0, 3);
    if (end_kind == 1) units.push_back(blank_unit());
    foreach (units[i]) begin
      if ($urandom_range(0, 49) == 0)
        push_word(sdtp_pkg::unit_t'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b0);
      push_word(units[i], 1'b1, end_kind != 0 && i == units.size() - 1);
    end
    if (end_kind == 0 || units.size() == 0)
      push_word(sdtp_pkg::unit_t'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b1);
  endtask

  // driver
  int gap_left = 0;
  int burst_left = 1;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_took) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (word_q.size() == 0 || (word_q[0].drain && verdict_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word_q[0].text_unit;
        s_axis_tuser  <= word_q[0].unit_valid;
        s_axis_tlast  <= word_q[0].last;
        void'(word_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   rx_tick = 0;
  int   rx_mode = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 160 == 0) rx_mode <= $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_taken >= 12) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1) == 1;
          2:       m_axis_tready <= $urandom_range(0, 3) == 0;
          default: m_axis_tready <= rx_tick[2:0] != 3'd0 && rx_tick[4:3] != 2'd2;
        endcase
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    sandbox_verdict_t want;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        results_taken <= results_taken + 1;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_axis_tdata);
          err_count++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[15:0] != want.flags) begin
            $display("%0t: flags mismatch: expected %h actual %h",
                     $time, want.flags, m_axis_tdata[15:0]);
            err_count++;
          end
          if (m_axis_tdata[28:16] != want.found) begin
            $display("%0t: keywords_found mismatch: expected %h actual %h",
                     $time, want.found, m_axis_tdata[28:16]);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) take_unit(s_axis_tdata);
        if (s_axis_tlast) begin
          close_token();
          verdict_q.push_back('{sandbox_flags(seen_kw), seen_kw});
          seen_kw = '0;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("sandbox_directive_token_parser test failed");
    $finish;
  end

  initial begin
    int n_dir;
    push_text("ALLOW-forms", 1'b1);
    push_word(16'hFFFF, 1'b1, 1'b0);
    push_word(16'h0080, 1'b1, 1'b0);
    push_word(16'h0020, 1'b1, 1'b0);
    push_word(16'h0009, 1'b1, 1'b0);
    push_word(16'hFFFF, 1'b0, 1'b0);
    push_word(16'h0000, 1'b0, 1'b1);
    push_word(16'h007F, 1'b1, 1'b0);
    push_word(16'h0000, 1'b1, 1'b0);
    push_word(16'h000A, 1'b1, 1'b0);
    push_word(16'h000C, 1'b1, 1'b0);
    push_word(16'h000D, 1'b1, 1'b0);
    push_word(16'h007A, 1'b1, 1'b1);
    push_word(16'hA5A5, 1'b0, 1'b1);

    n_dir = 0;
    while (words_made < 1650 || n_dir < 60) begin
      if (n_dir % 12 == 7) drain_next = 1'b1;
      add_directive();
      n_dir++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (word_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);

    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("sandbox_directive_token_parser test passed");
    end else begin
      $display("sandbox_directive_token_parser test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/sdtp_pkg.sv
rtl/sdtp_token_match.sv
rtl/sdtp_out_reg.sv
rtl/sandbox_directive_token_parser.sv
dv/tb_sandbox_directive_token_parser.sv
